// ===== hdl/fmdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, register indexes and the arctangent table of the
// FM discriminator with clamp and squelch. No dependencies.
package fmdc_pkg;

    localparam int IQ_W          = 16;
    localparam int GAIN_W        = 16;
    localparam int CLAMP_W       = 15;
    localparam int DEV_W         = 16;
    localparam int PROD_W        = 2 * IQ_W + 1;
    localparam int XY_W          = PROD_W + 2;
    localparam int ANG_W         = 33;
    localparam int MUL_W         = 18;
    localparam int ACC_W         = 50;
    localparam int SCALE_SHIFT   = 28;
    localparam int DEV_RAW_W     = ACC_W - SCALE_SHIFT;
    localparam int CORDIC_STAGES = 16;
    localparam int STEP_W        = $clog2(CORDIC_STAGES);
    localparam int ATAN_IDX_W    = 5;
    localparam int MAX_BLOCK     = 4096;
    localparam int CNT_W         = $clog2(MAX_BLOCK + 1);

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd2560;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd8192;

    localparam logic signed [ANG_W-1:0] HALF_PI    = 33'sd1073741824;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 50'sd134217728;

    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_CLAMP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_LOAD,
        ST_ROT,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic iter;
    } cordic_ctl_t;

    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 33'sd536870912;
            5'd1:    val = 33'sd316933406;
            5'd2:    val = 33'sd167458907;
            5'd3:    val = 33'sd85004756;
            5'd4:    val = 33'sd42667331;
            5'd5:    val = 33'sd21354465;
            5'd6:    val = 33'sd10679838;
            5'd7:    val = 33'sd5340245;
            5'd8:    val = 33'sd2670163;
            5'd9:    val = 33'sd1335087;
            5'd10:   val = 33'sd667544;
            5'd11:   val = 33'sd333772;
            5'd12:   val = 33'sd166886;
            5'd13:   val = 33'sd83443;
            5'd14:   val = 33'sd41722;
            5'd15:   val = 33'sd20861;
            5'd16:   val = 33'sd10430;
            5'd17:   val = 33'sd5215;
            5'd18:   val = 33'sd2608;
            5'd19:   val = 33'sd1304;
            5'd20:   val = 33'sd652;
            5'd21:   val = 33'sd326;
            5'd22:   val = 33'sd163;
            5'd23:   val = 33'sd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/fm_discriminator_clamp_squelch.sv =====
`timescale 1ns / 1ps
// FM quadrature discriminator with deviation clamp and clamp-rate squelch.
// Depends on fmdc_pkg, fmdc_mac, fmdc_cordic and fmdc_squelch.
//
// Usage: a sample request (iq_re, iq_im, last_of_block) is taken on a rising
// edge with in_valid high and in_stall low. Each sample yields one result
// request (deviation, was_clamped, squelch_on, block_end) on the output
// channel, taken when out_valid is high and out_stall is low.
// The block takes no new sample until it is through with the last one: four
// multiply-accumulate steps on the shared 18 by 18 multiplier form the
// conjugate product, a load step starts the CORDIC, which then rotates on its
// single shift-and-add unit, and two more multiplier steps apply the gain.
// The result is registered and appears in the same cycle that in_stall goes low.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next sample and then waits with in_stall high until the
// register is free. Stalled results hold their value.
// Reset sets gain to 2560, clamp level to 8192, clears the previous sample and
// the block counters, and starts with squelch on. The registers gain (index 0)
// and clamp_level (index 1) are written through cfg_we, cfg_index, cfg_data;
// the user must write them only while idle; the block does not enforce this.
module fm_discriminator_clamp_squelch (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [fmdc_pkg::IQ_W-1:0]       iq_re,
    input  logic signed [fmdc_pkg::IQ_W-1:0]       iq_im,
    input  logic                                   last_of_block,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [fmdc_pkg::DEV_W-1:0]      deviation,
    output logic                                   was_clamped,
    output logic                                   squelch_on,
    output logic                                   block_end,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [fmdc_pkg::GAIN_W-1:0]            cfg_data
);

    localparam int STEP_W = fmdc_pkg::STEP_W;
    localparam logic [STEP_W-1:0] STEP_LAST_ROT = STEP_W'(fmdc_pkg::CORDIC_STAGES - 1);
    localparam logic [STEP_W-1:0] STEP_LAST_PROD = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_LAST_SCALE = STEP_W'(1);

    fmdc_pkg::state_t                 state_reg, state_next;
    logic [STEP_W-1:0]                step_reg, step_next;
    logic [fmdc_pkg::GAIN_W-1:0]      gain_reg;
    logic [fmdc_pkg::CLAMP_W-1:0]     clamp_reg;
    logic signed [fmdc_pkg::IQ_W-1:0] cur_re_reg, cur_im_reg, prev_re_reg, prev_im_reg;
    logic                             last_reg;
    logic signed [fmdc_pkg::PROD_W-1:0] rr_reg, ri_reg;
    logic signed [fmdc_pkg::ACC_W-1:0]  acc_reg;
    logic                             out_valid_reg;
    logic signed [fmdc_pkg::DEV_W-1:0] dev_out_reg;
    logic                             hit_out_reg, muted_out_reg, end_out_reg;

    logic                             accept, commit, out_free;
    fmdc_pkg::cordic_ctl_t            cordic_ctl;
    logic signed [fmdc_pkg::MUL_W-1:0] mac_a, mac_b;
    logic signed [fmdc_pkg::ACC_W-1:0] mac_base, mac_sum;
    logic                             mac_sub, mac_shift;
    logic signed [fmdc_pkg::ANG_W-1:0] angle;
    logic signed [fmdc_pkg::DEV_W-1:0] dev;
    logic                             hit, muted_now;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            fmdc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fmdc_pkg::ST_PROD;
                    step_next  = '0;
                end
            end
            fmdc_pkg::ST_PROD:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST_PROD)
                begin
                    state_next = fmdc_pkg::ST_LOAD;
                    step_next  = '0;
                end
            end
            fmdc_pkg::ST_LOAD:
            begin
                state_next = fmdc_pkg::ST_ROT;
                step_next  = '0;
            end
            fmdc_pkg::ST_ROT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST_ROT)
                begin
                    state_next = fmdc_pkg::ST_SCALE;
                    step_next  = '0;
                end
            end
            fmdc_pkg::ST_SCALE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST_SCALE)
                begin
                    state_next = fmdc_pkg::ST_DONE;
                    step_next  = '0;
                end
            end
            fmdc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fmdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmdc_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall        = 1'b1;
        cordic_ctl.load = 1'b0;
        cordic_ctl.iter = 1'b0;
        commit          = 1'b0;
        case (state_reg)
            fmdc_pkg::ST_IDLE:  in_stall = 1'b0;
            fmdc_pkg::ST_LOAD:  cordic_ctl.load = 1'b1;
            fmdc_pkg::ST_ROT:   cordic_ctl.iter = 1'b1;
            fmdc_pkg::ST_DONE:  commit = out_free;
            default:            in_stall = 1'b1;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mac_a     = fmdc_pkg::MUL_W'(cur_re_reg);
        mac_b     = fmdc_pkg::MUL_W'(prev_re_reg);
        mac_base  = '0;
        mac_sub   = 1'b0;
        mac_shift = 1'b0;
        if (state_reg == fmdc_pkg::ST_SCALE)
        begin
            mac_b = fmdc_pkg::MUL_W'(signed'({1'b0, gain_reg}));
            if (step_reg[0])
            begin
                mac_a     = fmdc_pkg::MUL_W'(signed'(angle[fmdc_pkg::ANG_W-1:16]));
                mac_base  = acc_reg;
                mac_shift = 1'b1;
            end
            else
            begin
                mac_a    = fmdc_pkg::MUL_W'(signed'({1'b0, angle[15:0]}));
                mac_base = fmdc_pkg::ROUND_BIAS;
            end
        end
        else
        begin
            case (step_reg[1:0])
                2'd0:
                begin
                    mac_a = fmdc_pkg::MUL_W'(cur_re_reg);
                    mac_b = fmdc_pkg::MUL_W'(prev_re_reg);
                end
                2'd1:
                begin
                    mac_a    = fmdc_pkg::MUL_W'(cur_im_reg);
                    mac_b    = fmdc_pkg::MUL_W'(prev_im_reg);
                    mac_base = fmdc_pkg::ACC_W'(rr_reg);
                end
                2'd2:
                begin
                    mac_a = fmdc_pkg::MUL_W'(cur_im_reg);
                    mac_b = fmdc_pkg::MUL_W'(prev_re_reg);
                end
                default:
                begin
                    mac_a    = fmdc_pkg::MUL_W'(cur_re_reg);
                    mac_b    = fmdc_pkg::MUL_W'(prev_im_reg);
                    mac_base = fmdc_pkg::ACC_W'(ri_reg);
                    mac_sub  = 1'b1;
                end
            endcase
        end
    end

    fmdc_mac u_mac (
        .op_a     (mac_a),
        .op_b     (mac_b),
        .base     (mac_base),
        .sub      (mac_sub),
        .shift_hi (mac_shift),
        .sum      (mac_sum)
    );

    fmdc_cordic u_cordic (
        .clk    (clk),
        .ctl    (cordic_ctl),
        .idx    (fmdc_pkg::ATAN_IDX_W'(step_reg)),
        .vec_re (rr_reg),
        .vec_im (ri_reg),
        .angle  (angle)
    );

    fmdc_squelch u_squelch (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (commit),
        .dev_raw     (acc_reg[fmdc_pkg::ACC_W-1:fmdc_pkg::SCALE_SHIFT]),
        .clamp_level (clamp_reg),
        .last        (last_reg),
        .dev         (dev),
        .hit         (hit),
        .muted_now   (muted_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmdc_pkg::ST_IDLE;
            step_reg      <= '0;
            gain_reg      <= fmdc_pkg::GAIN_RESET;
            clamp_reg     <= fmdc_pkg::CLAMP_RESET;
            prev_re_reg   <= '0;
            prev_im_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                if (cfg_index == fmdc_pkg::REG_GAIN)
                begin
                    gain_reg <= cfg_data;
                end
                else if (cfg_index == fmdc_pkg::REG_CLAMP)
                begin
                    clamp_reg <= cfg_data[fmdc_pkg::CLAMP_W-1:0];
                end
            end
            if (commit)
            begin
                prev_re_reg   <= cur_re_reg;
                prev_im_reg   <= cur_im_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_re_reg <= iq_re;
            cur_im_reg <= iq_im;
            last_reg   <= last_of_block;
        end
        if (state_reg == fmdc_pkg::ST_PROD)
        begin
            if (step_reg[1])
            begin
                ri_reg <= mac_sum[fmdc_pkg::PROD_W-1:0];
            end
            else
            begin
                rr_reg <= mac_sum[fmdc_pkg::PROD_W-1:0];
            end
        end
        if (state_reg == fmdc_pkg::ST_SCALE)
        begin
            acc_reg <= mac_sum;
        end
        if (commit)
        begin
            dev_out_reg   <= dev;
            hit_out_reg   <= hit;
            muted_out_reg <= muted_now;
            end_out_reg   <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign deviation   = dev_out_reg;
    assign was_clamped = hit_out_reg;
    assign squelch_on  = muted_out_reg;
    assign block_end   = end_out_reg;

endmodule

// ===== hdl/fmdc_mac.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a post-adder, used for the conjugate product
// and for the gain scaling. Depends on fmdc_pkg.
module fmdc_mac (
    input  logic signed [fmdc_pkg::MUL_W-1:0] op_a,
    input  logic signed [fmdc_pkg::MUL_W-1:0] op_b,
    input  logic signed [fmdc_pkg::ACC_W-1:0] base,
    input  logic                              sub,
    input  logic                              shift_hi,
    output logic signed [fmdc_pkg::ACC_W-1:0] sum
);

    logic signed [2*fmdc_pkg::MUL_W-1:0] prod;
    logic signed [fmdc_pkg::ACC_W-1:0]   prod_ext;
    logic signed [fmdc_pkg::ACC_W-1:0]   addend;

    always_comb
    begin
        prod     = op_a * op_b;
        prod_ext = fmdc_pkg::ACC_W'(prod);
        addend   = shift_hi ? (prod_ext <<< 16) : prod_ext;
        sum      = sub ? (base - addend) : (base + addend);
    end

endmodule

// ===== hdl/fmdc_cordic.sv =====
`timescale 1ns / 1ps
// Iterative vectoring CORDIC: one micro-rotation per cycle on a single
// shift-and-add unit, giving the binary angle of a vector. Depends on fmdc_pkg.
module fmdc_cordic (
    input  logic                                   clk,
    input  fmdc_pkg::cordic_ctl_t                  ctl,
    input  logic [fmdc_pkg::ATAN_IDX_W-1:0]        idx,
    input  logic signed [fmdc_pkg::PROD_W-1:0]     vec_re,
    input  logic signed [fmdc_pkg::PROD_W-1:0]     vec_im,
    output logic signed [fmdc_pkg::ANG_W-1:0]      angle
);

    logic signed [fmdc_pkg::XY_W-1:0]  x_reg, x_next;
    logic signed [fmdc_pkg::XY_W-1:0]  y_reg, y_next;
    logic signed [fmdc_pkg::ANG_W-1:0] z_reg, z_next;
    logic                              zero_reg, zero_next;
    logic signed [fmdc_pkg::XY_W-1:0]  re_ext, im_ext, xs, ys;
    logic signed [fmdc_pkg::ANG_W-1:0] step_ang;

    always_comb
    begin
        re_ext    = fmdc_pkg::XY_W'(vec_re);
        im_ext    = fmdc_pkg::XY_W'(vec_im);
        xs        = x_reg >>> idx;
        ys        = y_reg >>> idx;
        step_ang  = fmdc_pkg::atan_lut(idx);
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        if (ctl.load)
        begin
            zero_next = (vec_re == '0) && (vec_im == '0);
            if (vec_re < 0)
            begin
                if (vec_im >= 0)
                begin
                    x_next = im_ext;
                    y_next = -re_ext;
                    z_next = fmdc_pkg::HALF_PI;
                end
                else
                begin
                    x_next = -im_ext;
                    y_next = re_ext;
                    z_next = -fmdc_pkg::HALF_PI;
                end
            end
            else
            begin
                x_next = re_ext;
                y_next = im_ext;
                z_next = '0;
            end
        end
        else if (ctl.iter)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_ang;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign angle = zero_reg ? '0 : z_reg;

endmodule

// ===== hdl/fmdc_squelch.sv =====
`timescale 1ns / 1ps
// Deviation clamp, saturating block counters and the clamp-rate squelch
// decision taken at each block end. Depends on fmdc_pkg.
module fmdc_squelch (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    commit,
    input  logic signed [fmdc_pkg::DEV_RAW_W-1:0]   dev_raw,
    input  logic [fmdc_pkg::CLAMP_W-1:0]            clamp_level,
    input  logic                                    last,
    output logic signed [fmdc_pkg::DEV_W-1:0]       dev,
    output logic                                    hit,
    output logic                                    muted_now
);

    localparam int CMP_W = fmdc_pkg::DEV_RAW_W + 1;
    localparam int CNT_W_L = fmdc_pkg::CNT_W;
    localparam int RAT_W = CNT_W_L + 7;
    localparam logic [CNT_W_L-1:0] CNT_MAX = CNT_W_L'(fmdc_pkg::MAX_BLOCK);

    logic [CNT_W_L-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CNT_W_L-1:0] smp_cnt_reg, smp_cnt_next;
    logic               muted_reg, muted_next;
    logic signed [CMP_W-1:0] d_ext, lim, d_sel;
    logic [CNT_W_L-1:0] hit_inc, smp_inc;
    logic [RAT_W-1:0]   n_ext, h16, h128;

    always_comb
    begin
        d_ext = CMP_W'(dev_raw);
        lim   = CMP_W'(signed'({1'b0, clamp_level}));
        hit   = 1'b1;
        if (d_ext >= lim)
        begin
            d_sel = lim;
        end
        else if (d_ext <= -lim)
        begin
            d_sel = -lim;
        end
        else
        begin
            d_sel = d_ext;
            hit   = 1'b0;
        end
        dev = d_sel[fmdc_pkg::DEV_W-1:0];

        smp_inc = (smp_cnt_reg < CNT_MAX) ? smp_cnt_reg + 1'b1 : smp_cnt_reg;
        hit_inc = (hit && (hit_cnt_reg < CNT_MAX)) ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
        n_ext   = RAT_W'(smp_inc);
        h16     = RAT_W'({hit_inc, 4'b0000});
        h128    = {hit_inc, 7'b0000000};

        muted_now    = muted_reg;
        hit_cnt_next = hit_inc;
        smp_cnt_next = smp_inc;
        if (last)
        begin
            if (h16 > n_ext)
            begin
                muted_now = 1'b1;
            end
            else if (h128 < n_ext)
            begin
                muted_now = 1'b0;
            end
            hit_cnt_next = '0;
            smp_cnt_next = '0;
        end
        muted_next = muted_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg <= '0;
            smp_cnt_reg <= '0;
            muted_reg   <= 1'b1;
        end
        else if (commit)
        begin
            hit_cnt_reg <= hit_cnt_next;
            smp_cnt_reg <= smp_cnt_next;
            muted_reg   <= muted_next;
        end
    end

endmodule

// ===== dv/fm_discriminator_clamp_squelch_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fm_discriminator_clamp_squelch. It sends sample requests,
// predicts every result request with its own CORDIC, clamp and squelch model, and
// compares the outputs. Depends on fmdc_pkg and the block under test.
module fm_discriminator_clamp_squelch_test;
    import fmdc_pkg::*;

    typedef struct {
        logic signed [IQ_W-1:0] re;
        logic signed [IQ_W-1:0] im;
        logic                   last;
    } iq_sample_t;

    typedef struct packed {
        logic [DEV_W-1:0] deviation;
        logic             clamped;
        logic             squelched;
        logic             end_of_block;
    } demod_result_t;

    localparam longint QUARTER_TURN = 64'sd1073741824;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [IQ_W-1:0]  iq_re = '0;
    logic signed [IQ_W-1:0]  iq_im = '0;
    logic                    last_of_block = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [DEV_W-1:0] deviation;
    logic                    was_clamped;
    logic                    squelch_on;
    logic                    block_end;
    logic                    cfg_we = 1'b0;
    logic                    cfg_index = REG_GAIN;
    logic [GAIN_W-1:0]       cfg_data = '0;

    fm_discriminator_clamp_squelch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .iq_re         (iq_re),
        .iq_im         (iq_im),
        .last_of_block (last_of_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .deviation     (deviation),
        .was_clamped   (was_clamped),
        .squelch_on    (squelch_on),
        .block_end     (block_end),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    longint arctan_step [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    int     gain_setting = GAIN_RESET;
    int     clamp_setting = CLAMP_RESET;
    longint last_re = 0;
    longint last_im = 0;
    int     block_hits = 0;
    int     block_samples = 0;
    logic   muted = 1'b1;

    iq_sample_t    pending_samples[$];
    demod_result_t awaited_results[$];
    int            mismatches = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    bit            no_idle = 1'b0;
    logic          in_taken = 1'b0;

    function automatic demod_result_t discriminate(input iq_sample_t s);
        longint        cr, ci, x, y, z, xs, ys, t, d, lim;
        logic          hit;
        int            k;
        demod_result_t res;
        cr = s.re;
        ci = s.im;
        x = cr * last_re + ci * last_im;
        y = ci * last_re - cr * last_im;
        z = 0;
        if (x != 0 || y != 0)
        begin
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = QUARTER_TURN;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -QUARTER_TURN;
                end
            end
            for (k = 0; k < CORDIC_STAGES; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + arctan_step[k];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - arctan_step[k];
                end
            end
        end
        d = (z * gain_setting + (64'sd1 <<< 27)) >>> 28;
        lim = clamp_setting;
        hit = 1'b0;
        last_re = cr;
        last_im = ci;
        if (d >= lim)
        begin
            d = lim;
            hit = 1'b1;
        end
        else if (d <= -lim)
        begin
            d = -lim;
            hit = 1'b1;
        end
        if (block_samples < MAX_BLOCK)
            block_samples++;
        if (hit && block_hits < MAX_BLOCK)
            block_hits++;
        if (s.last)
        begin
            if (16 * block_hits > block_samples)
                muted = 1'b1;
            else if (128 * block_hits < block_samples)
                muted = 1'b0;
            block_hits = 0;
            block_samples = 0;
        end
        res.deviation = d[DEV_W-1:0];
        res.clamped = hit;
        res.squelched = muted;
        res.end_of_block = s.last;
        return res;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r >= 8)
            return 0;
        if (r == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 4);
    endfunction

    always @(negedge clk)
    begin
        iq_sample_t s;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                s = pending_samples.pop_front();
                iq_re <= s.re;
                iq_im <= s.im;
                last_of_block <= s.last;
                in_valid <= 1'b1;
                send_gap <= idle_length();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left <= idle_length();
        end
    end

    always @(posedge clk)
    begin
        iq_sample_t    taken;
        demod_result_t want;
        demod_result_t seen;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            taken.re = iq_re;
            taken.im = iq_im;
            taken.last = last_of_block;
            awaited_results = {awaited_results, discriminate(taken)};
        end
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {deviation, was_clamped, squelch_on, block_end};
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result dev %0d clamped %0b squelch %0b end %0b",
                         $time, deviation, was_clamped, squelch_on, block_end);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (seen !== want)
                begin
                    $display("%0t: expected dev %0d clamped %0b squelch %0b end %0b, %s",
                             $time, $signed(want.deviation), want.clamped, want.squelched,
                             want.end_of_block, "got");
                    $display("%0t:      got dev %0d clamped %0b squelch %0b end %0b",
                             $time, deviation, was_clamped, squelch_on, block_end);
                    mismatches++;
                end
            end
        end
    end

    function automatic void queue_sample(input int re, input int im, input logic last);
        iq_sample_t s;
        s.re = re[IQ_W-1:0];
        s.im = im[IQ_W-1:0];
        s.last = last;
        pending_samples = {pending_samples, s};
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    // One block of samples: mostly a tone with occasional phase jumps, otherwise
    // noise, full-scale corners or values close to zero.
    function automatic int queue_block();
        int  len, style, k, re, im;
        real amp, phase, step;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 250) : $urandom_range(1, 40);
        style = $urandom_range(0, 9);
        amp = real'($urandom_range(1, 32767));
        phase = real'($urandom_range(0, 6283)) / 1000.0;
        step = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 3.14159265;
        if ($urandom_range(0, 9) < 7)
            step = step * 0.3;
        for (k = 0; k < len; k++)
        begin
            if (style <= 5)
            begin
                phase = phase + step;
                if ($urandom_range(0, 24) == 0)
                    phase = phase + real'($urandom_range(0, 6283)) / 1000.0;
                re = $rtoi(amp * $cos(phase));
                im = $rtoi(amp * $sin(phase));
            end
            else if (style <= 7)
            begin
                re = $urandom();
                im = $urandom();
            end
            else if (style == 8)
            begin
                re = extreme_value();
                im = extreme_value();
            end
            else
            begin
                re = int'($urandom_range(0, 8)) - 4;
                im = int'($urandom_range(0, 8)) - 4;
            end
            queue_sample(re, im, k == len - 1);
        end
        return len;
    endfunction

    task automatic write_register(input logic index, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value[GAIN_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == REG_GAIN)
            gain_setting = value & 32'hFFFF;
        else
            clamp_setting = value & 32'h7FFF;
    endtask

    task automatic wait_drained();
        int calm;
        calm = 0;
        while (calm < 4)
        begin
            @(negedge clk);
            if (pending_samples.size() == 0 && !in_valid && awaited_results.size() == 0)
                calm++;
            else
                calm = 0;
        end
    endtask

    initial
    begin
        int p, n, k;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // The first sample meets a cleared history, so the product is zero;
        // the second lands on the negative real axis.
        queue_sample(32767, 0, 1'b0);
        queue_sample(-32768, 0, 1'b0);
        queue_sample(-32768, -32768, 1'b0);
        queue_sample(32767, 32767, 1'b0);
        queue_sample(0, -32768, 1'b0);
        queue_sample(0, 0, 1'b0);
        queue_sample(-1, 1, 1'b0);
        queue_sample(1, -1, 1'b1);
        for (k = 0; k < 10; k++)
            queue_sample(12345, -6789, k == 9);
        queue_sample(-12345, 6789, 1'b1);
        queue_sample(0, 0, 1'b1);
        wait_drained();

        for (p = 0; p < 11; p++)
        begin
            case (p)
                0:
                begin
                    write_register(REG_GAIN, 0);
                    write_register(REG_CLAMP, 32767);
                end
                1:
                begin
                    write_register(REG_GAIN, 65535);
                    write_register(REG_CLAMP, 0);
                end
                2:
                begin
                    write_register(REG_GAIN, 65535);
                    write_register(REG_CLAMP, 32767);
                end
                3:
                begin
                    write_register(REG_GAIN, GAIN_RESET);
                    write_register(REG_CLAMP, 1);
                end
                default:
                begin
                    write_register(REG_GAIN, $urandom_range(0, 65535));
                    if ($urandom_range(0, 2) == 0)
                        write_register(REG_CLAMP, $urandom_range(0, 64));
                    else
                        write_register(REG_CLAMP, $urandom_range(0, 32767));
                end
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < 115)
                n += queue_block();
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fmdc_pkg.sv
hdl/fmdc_mac.sv
hdl/fmdc_cordic.sv
hdl/fmdc_squelch.sv
hdl/fm_discriminator_clamp_squelch.sv
dv/fm_discriminator_clamp_squelch_test.sv
